// ----- hw/rtl/duration_text_parser_macros.svh -----
// Assertion macros for the duration text parser.
// Expect signals clk and rst_n in the scope of use; no other dependencies.
`ifndef DURATION_TEXT_PARSER_MACROS_SVH
`define DURATION_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define DTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define DTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dtp_pkg.sv -----
// Shared types and constants for the duration text parser.
// No dependencies; used by dtp_result_if, dtp_step and duration_text_parser.
package dtp_pkg;

  localparam int unsigned SECS_W = 32;
  localparam int unsigned MS_W   = 10;
  localparam int unsigned STAT_W = 2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam logic [5:0]      SECS_PER_MIN = 6'd60;
  localparam logic [3:0]      DEC_BASE     = 4'd10;
  localparam logic [MS_W-1:0] MS_MAX       = 10'd999;
  localparam logic [1:0]      MAX_COLONS   = 2'd2;

  // Error flag bits
  localparam int unsigned FLAG_EMPTY_BIT = 0;
  localparam int unsigned FLAG_SAT_BIT   = 1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_INT  = 3'b010,
    PH_FRAC = 3'b100
  } phase_t;

  typedef struct packed {
    logic [SECS_W-1:0] folded_total;
    logic [SECS_W-1:0] group_value;
    logic [MS_W-1:0]   fraction_value;
    logic [1:0]        colon_count;
    phase_t            parse_phase;
    logic              group_has_digit;
    logic [1:0]        error_flags;
  } parse_state_t;

  typedef struct packed {
    logic [SECS_W-1:0] total_seconds;
    logic [MS_W-1:0]   milliseconds;
    logic [STAT_W-1:0] status;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    folded_total:    '0,
    group_value:     '0,
    fraction_value:  '0,
    colon_count:     '0,
    parse_phase:     PH_SKIP,
    group_has_digit: 1'b0,
    error_flags:     '0
  };

endpackage

// ----- hw/rtl/dtp_chan_if.sv -----
// Valid/ready channel interfaces for the duration text parser.
// Depends on dtp_pkg for field widths.
interface dtp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface dtp_result_if;
  logic                            valid;
  logic                            ready;
  logic [dtp_pkg::SECS_W-1:0]      total_seconds;
  logic [dtp_pkg::MS_W-1:0]        milliseconds;
  logic [dtp_pkg::STAT_W-1:0]      status;

  modport source (output valid, output total_seconds, output milliseconds,
                  output status, input ready);
  modport sink   (input valid, input total_seconds, input milliseconds,
                  input status, output ready);
endinterface

// ----- hw/rtl/dtp_step.sv -----
// Next-state and result logic for one character of the duration parser.
// Depends on dtp_pkg.
module dtp_step (
  input  dtp_pkg::parse_state_t state_cur,
  input  logic [7:0]            char_cur,
  output dtp_pkg::parse_state_t state_nxt,
  output logic                  res_valid,
  output dtp_pkg::result_t      res
);

  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] grp_w;
  logic [37:0] fold_w;
  logic [13:0] frac_w;
  logic        grp_sat;
  logic        fold_sat;
  logic        frac_sat;

  assign is_digit = (char_cur >= dtp_pkg::CHAR_ZERO) && (char_cur <= dtp_pkg::CHAR_NINE);
  assign digit    = char_cur[3:0];

  // Three short multiply-adds by constants, each with a range check
  assign grp_w  = 36'(state_cur.group_value) * 36'(dtp_pkg::DEC_BASE) + 36'(digit);
  assign fold_w = 38'(state_cur.folded_total) * 38'(dtp_pkg::SECS_PER_MIN)
                + 38'(state_cur.group_value);
  assign frac_w = 14'(state_cur.fraction_value) * 14'(dtp_pkg::DEC_BASE) + 14'(digit);

  assign grp_sat  = |grp_w[35:32];
  assign fold_sat = |fold_w[37:32];
  assign frac_sat = frac_w > 14'(dtp_pkg::MS_MAX);

  always_comb begin
    logic [1:0] flags;
    logic       fin;
    logic       in_int;

    state_nxt = state_cur;
    res_valid = 1'b0;
    res       = '0;
    flags     = state_cur.error_flags;
    fin       = 1'b0;
    in_int    = 1'b0;

    unique case (state_cur.parse_phase)
      dtp_pkg::PH_FRAC: begin
        if (is_digit) begin
          state_nxt.fraction_value  = frac_sat ? dtp_pkg::MS_MAX : frac_w[dtp_pkg::MS_W-1:0];
          state_nxt.group_has_digit = 1'b1;
          if (frac_sat) flags[dtp_pkg::FLAG_SAT_BIT] = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      dtp_pkg::PH_INT: begin
        in_int = 1'b1;
      end
      default: begin
        // Skip leading spaces; anything else opens the integer groups
        if (char_cur != dtp_pkg::CHAR_SPACE) begin
          state_nxt.parse_phase = dtp_pkg::PH_INT;
          in_int = 1'b1;
        end
      end
    endcase

    if (in_int) begin
      if (is_digit) begin
        state_nxt.group_value     = grp_sat ? '1 : grp_w[31:0];
        state_nxt.group_has_digit = 1'b1;
        if (grp_sat) flags[dtp_pkg::FLAG_SAT_BIT] = 1'b1;
      end else if (char_cur == dtp_pkg::CHAR_COLON &&
                   state_cur.colon_count < dtp_pkg::MAX_COLONS) begin
        if (!state_cur.group_has_digit) flags[dtp_pkg::FLAG_EMPTY_BIT] = 1'b1;
        if (fold_sat) flags[dtp_pkg::FLAG_SAT_BIT] = 1'b1;
        state_nxt.folded_total    = fold_sat ? '1 : fold_w[31:0];
        state_nxt.group_value     = '0;
        state_nxt.group_has_digit = 1'b0;
        state_nxt.colon_count     = 2'(state_cur.colon_count + 2'd1);
      end else if (char_cur == dtp_pkg::CHAR_DOT) begin
        if (!state_cur.group_has_digit) flags[dtp_pkg::FLAG_EMPTY_BIT] = 1'b1;
        state_nxt.group_has_digit = 1'b0;
        state_nxt.parse_phase     = dtp_pkg::PH_FRAC;
      end else begin
        fin = 1'b1;
      end
    end

    state_nxt.error_flags = flags;

    if (fin) begin
      if (!state_cur.group_has_digit) flags[dtp_pkg::FLAG_EMPTY_BIT] = 1'b1;
      if (fold_sat) flags[dtp_pkg::FLAG_SAT_BIT] = 1'b1;
      res_valid          = 1'b1;
      res.total_seconds  = fold_sat ? '1 : fold_w[31:0];
      res.milliseconds   = state_cur.fraction_value;
      if (flags[dtp_pkg::FLAG_EMPTY_BIT])    res.status = dtp_pkg::STAT_EMPTY;
      else if (flags[dtp_pkg::FLAG_SAT_BIT]) res.status = dtp_pkg::STAT_SAT;
      else                                   res.status = dtp_pkg::STAT_OK;
      state_nxt = dtp_pkg::STATE_RESET;
    end
  end

endmodule

// ----- hw/rtl/duration_text_parser.sv -----
// Top level of the duration text parser: input register, parse state, result register.
// Depends on dtp_pkg, dtp_chan_if, dtp_step and duration_text_parser_macros.svh.
//
//   channel   dir  payload                                    transfer when
//   in_chan   in   character[7:0]                              valid && ready
//   out_chan  out  total_seconds[31:0], milliseconds[9:0],     valid && ready
//                  status[1:0]
//
// One character per cycle while the result register is free or being taken. A
// character is held in the input register, then the parse step updates the state
// and, on a terminator, loads the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the parse
// state to skipping leading spaces. Hold the input register while the result
// register is full and not taken; input stays ready while its register drains.
`include "duration_text_parser_macros.svh"

module duration_text_parser (
  input  logic                clk,
  input  logic                rst_n,
  dtp_char_if.sink            in_chan,
  dtp_result_if.source        out_chan
);

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;

  // Parse state and the step outputs
  dtp_pkg::parse_state_t state_r;
  dtp_pkg::parse_state_t state_nxt;
  logic                  step_res_valid;
  dtp_pkg::result_t      step_res;

  // Result register
  logic             out_valid_r;
  dtp_pkg::result_t out_res_r;

  logic advance;

  // Advance the held character whenever the result register can take a result
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  dtp_step u_step (
    .state_cur (state_r),
    .char_cur  (s1_char_r),
    .state_nxt (state_nxt),
    .res_valid (step_res_valid),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= dtp_pkg::STATE_RESET;
    end else begin
      if (in_chan.ready) s1_valid_r <= in_chan.valid;
      if (advance) state_r <= state_nxt;
      // Set on a fresh result, drop once the sink takes it
      if (advance && step_res_valid) out_valid_r <= 1'b1;
      else if (out_chan.ready)       out_valid_r <= 1'b0;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) s1_char_r <= in_chan.character;
    if (advance && step_res_valid) out_res_r <= step_res;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.total_seconds = out_res_r.total_seconds;
  assign out_chan.milliseconds  = out_res_r.milliseconds;
  assign out_chan.status        = out_res_r.status;

  // A third colon ends the parse, so the count never passes two
  `DTP_ASSERT_IMP(a_colon_bound, 1'b1, state_r.colon_count != 2'd3,
    "colon count out of range")

  // Milliseconds saturate at 999
  `DTP_ASSERT_IMP(a_ms_bound, out_valid_r, out_res_r.milliseconds <= dtp_pkg::MS_MAX,
    "milliseconds above limit")

  // A finished parse leaves the state as after reset
  `DTP_ASSERT_NXT(a_state_cleared, advance && step_res_valid,
    state_r == dtp_pkg::STATE_RESET && out_valid_r,
    "state not cleared after result")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for duration_text_parser: directed duration strings,
// then random well-formed durations with noise under four idling patterns.
// Depends on dtp_pkg, dtp_char_if, dtp_result_if and the duration_text_parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous watchdog for a slow correct run.
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  // Extra wait before declaring the block quiet.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Least count of non-ignored characters per random idling phase (four phases).
  localparam int unsigned PHASE_ITEMS   = 137;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dtp_char_if   char_bus ();
  dtp_result_if result_bus ();

  duration_text_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_bus),
    .out_chan (result_bus)
  );

  always #10 clk = ~clk;

  // Idling knobs, percent of cycles; changed only between phases.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned cycle_count = 0;
  int unsigned fault_count = 0;

  // Durations the parser owes us, oldest first.
  dtp_pkg::result_t pending_durations[$];

  // Shadow parse state, advanced once per accepted character.
  logic [dtp_pkg::SECS_W-1:0] shadow_total;
  logic [dtp_pkg::SECS_W-1:0] shadow_group;
  logic [dtp_pkg::MS_W-1:0]   shadow_frac;
  logic [1:0]                 shadow_colons;
  dtp_pkg::phase_t            shadow_phase;
  logic                       shadow_has_digit;
  logic                       shadow_empty;
  logic                       shadow_sat;

  task automatic report_fault(input string msg);
    $display("[%0t] FAULT: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic clear_shadow();
    shadow_total     = '0;
    shadow_group     = '0;
    shadow_frac      = '0;
    shadow_colons    = '0;
    shadow_phase     = dtp_pkg::PH_SKIP;
    shadow_has_digit = 1'b0;
    shadow_empty     = 1'b0;
    shadow_sat       = 1'b0;
  endtask

  // a*k+b held at all ones on overflow, which raises the saturation flag.
  function automatic logic [dtp_pkg::SECS_W-1:0] scale_add_sat(
      input logic [dtp_pkg::SECS_W-1:0] a,
      input logic [dtp_pkg::SECS_W-1:0] k,
      input logic [dtp_pkg::SECS_W-1:0] b);
    logic [63:0] wide;
    wide = 64'(a) * 64'(k) + 64'(b);
    if (wide > 64'(32'hFFFF_FFFF)) begin
      shadow_sat = 1'b1;
      return '1;
    end
    return wide[dtp_pkg::SECS_W-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= dtp_pkg::CHAR_ZERO) && (c <= dtp_pkg::CHAR_NINE);
  endfunction

  // Advance the shadow parse by one character; queue a duration when it ends.
  task automatic advance_parse(input logic [7:0] c);
    dtp_pkg::result_t done;
    logic             ends;
    int unsigned      frac_next;
    ends = 1'b0;
    if (shadow_phase == dtp_pkg::PH_FRAC) begin
      if (is_digit(c)) begin
        frac_next = 32'(shadow_frac) * 32'(dtp_pkg::DEC_BASE)
                  + (32'(c) - 32'(dtp_pkg::CHAR_ZERO));
        if (frac_next > 32'(dtp_pkg::MS_MAX)) begin
          frac_next  = 32'(dtp_pkg::MS_MAX);
          shadow_sat = 1'b1;
        end
        shadow_frac      = frac_next[dtp_pkg::MS_W-1:0];
        shadow_has_digit = 1'b1;
      end else begin
        ends = 1'b1;
      end
    end else if (!(shadow_phase == dtp_pkg::PH_SKIP && c == dtp_pkg::CHAR_SPACE)) begin
      // Anything but a leading space starts the integer groups.
      shadow_phase = dtp_pkg::PH_INT;
      if (is_digit(c)) begin
        shadow_group     = scale_add_sat(shadow_group, 32'(dtp_pkg::DEC_BASE),
                                         32'(c) - 32'(dtp_pkg::CHAR_ZERO));
        shadow_has_digit = 1'b1;
      end else if (c == dtp_pkg::CHAR_COLON && shadow_colons < dtp_pkg::MAX_COLONS) begin
        if (!shadow_has_digit) shadow_empty = 1'b1;
        shadow_total     = scale_add_sat(shadow_total, 32'(dtp_pkg::SECS_PER_MIN),
                                         shadow_group);
        shadow_group     = '0;
        shadow_has_digit = 1'b0;
        shadow_colons++;
      end else if (c == dtp_pkg::CHAR_DOT) begin
        if (!shadow_has_digit) shadow_empty = 1'b1;
        shadow_has_digit = 1'b0;
        shadow_phase     = dtp_pkg::PH_FRAC;
      end else begin
        // Third colon and any other stray character land here.
        ends = 1'b1;
      end
    end
    if (ends) begin
      if (!shadow_has_digit) shadow_empty = 1'b1;
      done.total_seconds = scale_add_sat(shadow_total, 32'(dtp_pkg::SECS_PER_MIN),
                                         shadow_group);
      done.milliseconds  = shadow_frac;
      // Empty group outranks saturation.
      if (shadow_empty)    done.status = dtp_pkg::STAT_EMPTY;
      else if (shadow_sat) done.status = dtp_pkg::STAT_SAT;
      else                 done.status = dtp_pkg::STAT_OK;
      pending_durations = {pending_durations, done};
      clear_shadow();
    end
  endtask

  // Offer one character; called at a falling edge, returns at a falling edge.
  // Valid is left high after the transfer so back-to-back items never glitch it.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      char_bus.valid     <= 1'b0;
      char_bus.character <= 8'($urandom);
      @(negedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.character <= c;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    advance_parse(c);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // Drop valid, wait for every owed duration, then let the pipeline settle.
  task automatic wait_drained();
    char_bus.valid <= 1'b0;
    while (pending_durations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One random duration: mostly well formed, sometimes trailed by noise.
  task automatic send_duration(output int unsigned counted);
    int unsigned groups;
    int unsigned ndig;
    int unsigned roll;
    logic        has_frac;
    logic [7:0]  term;
    counted = 0;
    // Leading spaces are swallowed by the block, so they are not counted.
    repeat ($urandom_range(0, 2)) send_char(dtp_pkg::CHAR_SPACE);
    groups = $urandom_range(1, 3);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) begin
        send_char(dtp_pkg::CHAR_COLON);
        counted++;
      end
      roll = $urandom_range(99);
      if (roll < 5)       ndig = 0;
      else if (roll < 14) ndig = $urandom_range(9, 11);
      else                ndig = $urandom_range(1, 3);
      repeat (ndig) begin
        send_char(dtp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        counted++;
      end
    end
    has_frac = 1'($urandom_range(1));
    if (has_frac) begin
      send_char(dtp_pkg::CHAR_DOT);
      counted++;
      ndig = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 4);
      repeat (ndig) begin
        send_char(dtp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        counted++;
      end
    end
    // Pick a terminator; colon and dot only where they really end the parse.
    roll = $urandom_range(99);
    if (roll < 25)                     term = dtp_pkg::CHAR_SPACE;
    else if (roll < 35 && groups == 3) term = dtp_pkg::CHAR_COLON;
    else if (roll < 45 && has_frac)    term = dtp_pkg::CHAR_DOT;
    else begin
      term = 8'($urandom_range(255));
      if (is_digit(term)) term = term ^ 8'h40;
    end
    send_char(term);
    counted++;
    // Occasional burst of raw bytes to exercise broken sequences.
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) begin
        send_char(8'($urandom));
        counted++;
      end
    end
  endtask

  // Full h:m:s with leading space, a fraction that saturates at 999,
  // ended by the largest character code.
  task automatic test_clock_forms();
    send_text(" 1:2:3.4567");
    send_char(8'hFF);
    wait_drained();
  endtask

  // Two empty groups closed by a third colon, then a dot with no fraction
  // digits closed by the smallest character code.
  task automatic test_empty_groups();
    send_text("::9:");
    send_text("7.");
    send_char(8'h00);
    wait_drained();
  endtask

  // Minutes that overflow when folded, then an empty seconds group: both
  // flags raised, empty must win.
  task automatic test_saturation();
    send_text("71582789:,");
    wait_drained();
  endtask

  task automatic test_random_durations(input int unsigned sender_pct,
                                       input int unsigned stall_pct);
    int unsigned counted;
    int unsigned total;
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = stall_pct;
    total = 0;
    while (total < PHASE_ITEMS) begin
      send_duration(counted);
      total += counted;
    end
    wait_drained();
  endtask

  // Receiver: decide ready afresh at every falling edge.
  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare every result transfer against the oldest owed duration.
  always @(posedge clk) begin
    dtp_pkg::result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending_durations.size() == 0) begin
        report_fault($sformatf("unexpected result: %0d s, %0d ms, status %0d",
                               result_bus.total_seconds, result_bus.milliseconds,
                               result_bus.status));
      end else begin
        want = pending_durations.pop_front();
        if (result_bus.total_seconds !== want.total_seconds)
          report_fault($sformatf("total_seconds: got %0d, want %0d",
                                 result_bus.total_seconds, want.total_seconds));
        if (result_bus.milliseconds !== want.milliseconds)
          report_fault($sformatf("milliseconds: got %0d, want %0d",
                                 result_bus.milliseconds, want.milliseconds));
        if (result_bus.status !== want.status)
          report_fault($sformatf("status: got %0d, want %0d",
                                 result_bus.status, want.status));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    // Hold every input at a known value from time zero.
    char_bus.valid     = 1'b0;
    char_bus.character = '0;
    result_bus.ready   = 1'b0;
    clear_shadow();

    // Reset held from time zero, released on a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_clock_forms();
    test_empty_groups();
    test_saturation();

    // Random phases: free running, sender idle, receiver stalling, both.
    test_random_durations(0, 0);
    test_random_durations(82, 0);
    test_random_durations(0, 82);
    test_random_durations(27, 27);

    if (pending_durations.size() != 0)
      report_fault($sformatf("%0d durations never arrived", pending_durations.size()));

    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
